/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check, disabled while reset is held
`define GPVC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gpvc assertion failed");

// a signal keeps its value in the cycle after cond
`define GPVC_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("gpvc hold assertion failed");

`endif

/* hw/rtl/gpvc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gpvc_pkg
// types, constants and the arctangent table of the go-to-point command block
// ----------------------------------------------------------------------------
package gpvc_pkg;

    // configuration register indexes
    localparam logic CFG_MAX_SPEED = 1'b0;
    localparam logic CFG_MAX_YAW   = 1'b1;

    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = 33;
    localparam int TABLE_LEN  = 24;

    // angles in units of 2^-30 rad, headings in Q2.13
    localparam logic signed [35:0] HALF_PI_A   = 36'sd1686629713;
    localparam logic signed [35:0] TWO_HALF_PI = 36'sd3373259426;
    localparam logic signed [30:0] CORDIC_GAIN = 31'sd652032874;
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [15:0] heading;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] vel_forward;
        logic signed [31:0] vel_left;
        logic signed [31:0] vel_up;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] heading_setpoint;
    } t_out_beat;

    // square root cell contents
    typedef struct packed {
        logic [63:0]        rad;
        logic [33:0]        rem;
        logic [31:0]        root;
        logic [2:0][32:0]   e;
        logic               h;
        logic signed [15:0] hd;
    } t_sq;

    // divider cell contents, three lanes x y z
    typedef struct packed {
        logic [2:0][32:0]   num;
        logic [2:0][33:0]   rem;
        logic [2:0][32:0]   q;
        logic [32:0]        den;
        logic [2:0][32:0]   e;
        logic               clamp;
        logic               zero;
        logic signed [15:0] hd;
    } t_dv;

    // cordic cell contents, vectoring and rotation side by side
    typedef struct packed {
        logic [2:0][31:0]   v;
        logic signed [15:0] hd;
        logic signed [35:0] vec_x;
        logic signed [35:0] vec_y;
        logic signed [35:0] vec_z;
        logic signed [35:0] rot_x;
        logic signed [35:0] rot_y;
        logic signed [35:0] rot_a;
    } t_cd;

    // arctangent of 2^-idx in 2^-30 rad
    function automatic logic signed [35:0] atan_val(input int unsigned idx);
        logic signed [35:0] v;
        unique case (idx)
            0:  v = 36'sd843314856;
            1:  v = 36'sd497837829;
            2:  v = 36'sd263043836;
            3:  v = 36'sd133525158;
            4:  v = 36'sd67021686;
            5:  v = 36'sd33543515;
            6:  v = 36'sd16775850;
            7:  v = 36'sd8388437;
            8:  v = 36'sd4194282;
            9:  v = 36'sd2097149;
            10: v = 36'sd1048575;
            11: v = 36'sd524287;
            12: v = 36'sd262143;
            13: v = 36'sd131071;
            14: v = 36'sd65535;
            15: v = 36'sd32767;
            16: v = 36'sd16383;
            17: v = 36'sd8191;
            18: v = 36'sd4095;
            19: v = 36'sd2047;
            20: v = 36'sd1023;
            21: v = 36'sd511;
            22: v = 36'sd255;
            23: v = 36'sd127;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/goto_point_velocity_command.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// goto_point_velocity_command
// velocity and yaw-rate command toward a target point, fully pipelined
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_in_beat  (t_in_beat)
//  out       output     o_out_valid / i_out_ready   o_out_beat (t_out_beat)
//  cfg       input      i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  one beat per cycle unless a result beat waits at the output; the line
//  is made up of the 32 square root cells, the 33 divider cells and the
//  cordic cell chain plus seven datapath stages
//  reset clears the valid line and loads the default speed and yaw clamps
//  the whole line holds while a result beat waits at the output
// ----------------------------------------------------------------------------
module goto_point_velocity_command
    import gpvc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_beat    i_in_beat,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_beat        o_out_beat,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);

    localparam int DEPTH = 7 + SQRT_CELLS + DIV_CELLS + CORDIC_STEPS;

    logic               w_en;
    logic [DEPTH-1:0]   r_vld;
    logic [30:0]        r_max_speed;
    logic [14:0]        r_max_yaw;

    // stage registers
    logic [2:0][32:0]   r_a_e;
    logic signed [15:0] r_a_hd;
    logic [2:0][61:0]   r_b_sq;
    logic [2:0][32:0]   r_b_e;
    logic               r_b_h;
    logic signed [15:0] r_b_hd;
    t_sq                r_c;
    t_dv                r_d;
    t_cd                r_e;
    logic signed [15:0] r_f_sp;
    logic signed [64:0] r_f_px;
    logic signed [64:0] r_f_py;
    logic [31:0]        r_f_vz;
    logic signed [15:0] r_f_hd;
    t_out_beat          r_out;

    t_sq                w_sq [SQRT_CELLS+1];
    t_dv                w_dv [DIV_CELLS+1];
    t_cd                w_cd [CORDIC_STEPS+1];

    assign w_en        = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[DEPTH-1];
    assign o_out_beat  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= 31'd327680;
            r_max_yaw   <= 15'd16384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_SPEED: r_max_speed <= i_cfg_data;
                CFG_MAX_YAW:   r_max_yaw   <= i_cfg_data[14:0];
            endcase
        end
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    // error vector
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_e[0] <= 33'($signed({i_in_beat.target_x[31], i_in_beat.target_x})
                          - $signed({i_in_beat.pos_x[31], i_in_beat.pos_x}));
            r_a_e[1] <= 33'($signed({i_in_beat.target_y[31], i_in_beat.target_y})
                          - $signed({i_in_beat.pos_y[31], i_in_beat.pos_y}));
            r_a_e[2] <= 33'($signed({i_in_beat.target_z[31], i_in_beat.target_z})
                          - $signed({i_in_beat.pos_z[31], i_in_beat.pos_z}));
            r_a_hd   <= i_in_beat.heading;
        end
    end

    // magnitudes, halving on large errors, squares
    logic [2:0][32:0] w_b_mag;
    logic [2:0][30:0] w_b_a;
    logic             w_b_h;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_b_mag[k] = r_a_e[k][32] ? 33'(-r_a_e[k]) : r_a_e[k];
        end
        w_b_h = (w_b_mag[0][32:31] != 2'b00) || (w_b_mag[1][32:31] != 2'b00)
             || (w_b_mag[2][32:31] != 2'b00);
        for (int k = 0; k < 3; k++) begin
            w_b_a[k] = w_b_h ? w_b_mag[k][31:1] : w_b_mag[k][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_b_sq[k] <= w_b_a[k] * w_b_a[k];
            end
            r_b_e  <= r_a_e;
            r_b_h  <= w_b_h;
            r_b_hd <= r_a_hd;
        end
    end

    // sum of squares loads the root chain
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c.rad  <= 64'(r_b_sq[0]) + 64'(r_b_sq[1]) + 64'(r_b_sq[2]);
            r_c.rem  <= '0;
            r_c.root <= '0;
            r_c.e    <= r_b_e;
            r_c.h    <= r_b_h;
            r_c.hd   <= r_b_hd;
        end
    end

    assign w_sq[0] = r_c;
    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        gpvc_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq[g]),
            .o_q   (w_sq[g+1])
        );
    end

    // length, clamp decision, numerators for the divider chain
    t_sq              w_d_in;
    logic [32:0]      w_d_len;
    logic [2:0][32:0] w_d_mag;
    logic [2:0][63:0] w_d_num;
    always_comb begin
        w_d_in  = w_sq[SQRT_CELLS];
        w_d_len = w_d_in.h ? {w_d_in.root, 1'b0} : {1'b0, w_d_in.root};
        for (int k = 0; k < 3; k++) begin
            w_d_mag[k] = w_d_in.e[k][32] ? 33'(-w_d_in.e[k]) : w_d_in.e[k];
            w_d_num[k] = 64'(w_d_mag[k] * r_max_speed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d.num[k] <= w_d_num[k][32:0];
                r_d.rem[k] <= {3'b000, w_d_num[k][63:33]};
                r_d.q[k]   <= '0;
            end
            r_d.den   <= w_d_len;
            r_d.e     <= w_d_in.e;
            r_d.clamp <= (w_d_len >= {2'b00, r_max_speed});
            r_d.zero  <= (w_d_len == '0) || (r_max_speed == '0);
            r_d.hd    <= w_d_in.hd;
        end
    end

    assign w_dv[0] = r_d;
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        gpvc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_dv[g]),
            .o_q   (w_dv[g+1])
        );
    end

    // heading in 2^-30 rad
    function automatic logic signed [35:0] hd_angle(input logic signed [15:0] hd);
        logic signed [35:0] v;
        v = 36'(hd);
        return v <<< 17;
    endfunction

    // velocity selection and saturation, cordic start values
    t_dv                w_e_in;
    logic [2:0][31:0]   w_e_v;
    logic signed [35:0] w_e_x;
    logic signed [35:0] w_e_y;
    logic signed [35:0] w_e_a;
    t_cd                n_e;
    always_comb begin
        w_e_in = w_dv[DIV_CELLS];
        for (int k = 0; k < 3; k++) begin
            if (w_e_in.zero) begin
                w_e_v[k] = '0;
            end else if (!w_e_in.clamp) begin
                w_e_v[k] = w_e_in.e[k][31:0];
            end else if (!w_e_in.e[k][32]) begin
                w_e_v[k] = (w_e_in.q[k] > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                           : w_e_in.q[k][31:0];
            end else begin
                w_e_v[k] = (w_e_in.q[k] >= 33'h0_8000_0000) ? 32'h8000_0000
                                                            : 32'(-w_e_in.q[k]);
            end
        end
        w_e_x = 36'($signed(w_e_v[0]));
        w_e_y = 36'($signed(w_e_v[1]));
        w_e_a = -(hd_angle(w_e_in.hd));

        n_e    = '0;
        n_e.v  = w_e_v;
        n_e.hd = w_e_in.hd;
        // vectoring start: fold the left half plane
        if (w_e_x < 36'sd0) begin
            if (w_e_y >= 36'sd0) begin
                n_e.vec_x = w_e_y;
                n_e.vec_y = -w_e_x;
                n_e.vec_z = HALF_PI_A;
            end else begin
                n_e.vec_x = -w_e_y;
                n_e.vec_y = w_e_x;
                n_e.vec_z = -HALF_PI_A;
            end
        end else begin
            n_e.vec_x = w_e_x;
            n_e.vec_y = w_e_y;
            n_e.vec_z = 36'sd0;
        end
        // rotation start: reduce by quarter turns
        if (w_e_a > TWO_HALF_PI) begin
            n_e.rot_x = -w_e_x;
            n_e.rot_y = -w_e_y;
            n_e.rot_a = w_e_a - TWO_HALF_PI;
        end else if (w_e_a > HALF_PI_A) begin
            n_e.rot_x = -w_e_y;
            n_e.rot_y = w_e_x;
            n_e.rot_a = w_e_a - HALF_PI_A;
        end else if (w_e_a < -TWO_HALF_PI) begin
            n_e.rot_x = -w_e_x;
            n_e.rot_y = -w_e_y;
            n_e.rot_a = w_e_a + TWO_HALF_PI;
        end else if (w_e_a < -HALF_PI_A) begin
            n_e.rot_x = w_e_y;
            n_e.rot_y = -w_e_x;
            n_e.rot_a = w_e_a + HALF_PI_A;
        end else begin
            n_e.rot_x = w_e_x;
            n_e.rot_y = w_e_y;
            n_e.rot_a = w_e_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e <= n_e;
        end
    end

    assign w_cd[0] = r_e;
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        gpvc_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_cd[g]),
            .o_q   (w_cd[g+1])
        );
    end

    // setpoint rounding and gain correction products
    t_cd                w_f_in;
    logic signed [35:0] w_f_z;
    logic signed [15:0] w_f_sp;
    always_comb begin
        w_f_in = w_cd[CORDIC_STEPS];
        w_f_z  = (w_f_in.vec_z + 36'sd65536) >>> 17;
        if (w_f_in.v[0] == '0 && w_f_in.v[1] == '0) begin
            w_f_sp = '0;
        end else if (w_f_z > 36'(PI_Q13)) begin
            w_f_sp = 16'(PI_Q13);
        end else if (w_f_z < -36'(PI_Q13)) begin
            w_f_sp = 16'(-PI_Q13);
        end else begin
            w_f_sp = w_f_z[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_sp <= w_f_sp;
            r_f_px <= $signed(w_f_in.rot_x[33:0]) * CORDIC_GAIN;
            r_f_py <= $signed(w_f_in.rot_y[33:0]) * CORDIC_GAIN;
            r_f_vz <= w_f_in.v[2];
            r_f_hd <= w_f_in.hd;
        end
    end

    // yaw error wrap and clamp, body velocity rounding and saturation
    logic signed [17:0] w_g_d0;
    logic signed [17:0] w_g_d;
    logic [17:0]        w_g_dmag;
    logic signed [15:0] w_g_yaw;
    logic signed [34:0] w_g_fx;
    logic signed [34:0] w_g_fy;
    t_out_beat          n_out;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb begin
        w_g_d0 = 18'(r_f_sp) - 18'(r_f_hd);
        if (w_g_d0 > PI_Q13) begin
            w_g_d = w_g_d0 - TWO_PI_Q13;
        end else if (w_g_d0 < -PI_Q13) begin
            w_g_d = w_g_d0 + TWO_PI_Q13;
        end else begin
            w_g_d = w_g_d0;
        end
        w_g_dmag = w_g_d[17] ? 18'(-w_g_d) : w_g_d;
        if (w_g_dmag >= {3'b000, r_max_yaw}) begin
            w_g_yaw = (w_g_d > 18'sd0) ? $signed({1'b0, r_max_yaw})
                                       : 16'(-$signed({1'b0, r_max_yaw}));
        end else begin
            w_g_yaw = w_g_d[15:0];
        end
        w_g_fx = 35'((r_f_px + 65'sd536870912) >>> 30);
        w_g_fy = 35'((r_f_py + 65'sd536870912) >>> 30);
        n_out.vel_forward      = sat32(w_g_fx);
        n_out.vel_left         = sat32(w_g_fy);
        n_out.vel_up           = r_f_vz;
        n_out.yaw_rate         = w_g_yaw;
        n_out.heading_setpoint = r_f_sp;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/gpvc_sqrt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gpvc_sqrt_cell
// one digit of the floor square root, two radicand bits per cell
// ----------------------------------------------------------------------------
module gpvc_sqrt_cell
    import gpvc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_sq  i_d,
    output t_sq       o_q
);

    t_sq         r_q;
    t_sq         n_q;
    logic [35:0] w_rem;
    logic [35:0] w_trial;
    logic        w_ge;

    // bring down two bits and try the next root bit
    always_comb begin
        n_q     = i_d;
        w_rem   = {i_d.rem, i_d.rad[63:62]};
        w_trial = {2'b00, i_d.root, 2'b01};
        w_ge    = (w_rem >= w_trial);
        n_q.rad  = {i_d.rad[61:0], 2'b00};
        n_q.rem  = w_ge ? 34'(w_rem - w_trial) : w_rem[33:0];
        n_q.root = {i_d.root[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

/* hw/rtl/gpvc_div_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gpvc_div_cell
// one quotient bit of the restoring divide, for all three axes
// ----------------------------------------------------------------------------
module gpvc_div_cell
    import gpvc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_dv  i_d,
    output t_dv       o_q
);

    t_dv         r_q;
    t_dv         n_q;
    logic [34:0] w_t   [3];
    logic [34:0] w_den;
    logic [2:0]  w_ge;

    // shift in the next numerator bit and subtract where it fits
    always_comb begin
        n_q   = i_d;
        w_den = {2'b00, i_d.den};
        for (int k = 0; k < 3; k++) begin
            w_t[k]      = {i_d.rem[k], i_d.num[k][32]};
            w_ge[k]     = (w_t[k] >= w_den);
            n_q.rem[k]  = w_ge[k] ? 34'(w_t[k] - w_den) : w_t[k][33:0];
            n_q.num[k]  = {i_d.num[k][31:0], 1'b0};
            n_q.q[k]    = {i_d.q[k][31:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

/* hw/rtl/gpvc_cordic_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gpvc_cordic_cell
// one micro-rotation of the vectoring chain and of the rotation chain
// ----------------------------------------------------------------------------
module gpvc_cordic_cell
    import gpvc_pkg::*;
#(
    parameter int unsigned STEP = 0
)
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_cd  i_d,
    output t_cd       o_q
);

    localparam logic signed [35:0] ATAN = atan_val(STEP);

    t_cd                r_q;
    t_cd                n_q;
    logic signed [35:0] w_vdx;
    logic signed [35:0] w_vdy;
    logic signed [35:0] w_rdx;
    logic signed [35:0] w_rdy;

    always_comb begin
        n_q   = i_d;
        w_vdx = i_d.vec_y >>> STEP;
        w_vdy = i_d.vec_x >>> STEP;
        w_rdx = i_d.rot_y >>> STEP;
        w_rdy = i_d.rot_x >>> STEP;
        // vectoring drives y toward zero
        if (i_d.vec_y > 36'sd0) begin
            n_q.vec_x = i_d.vec_x + w_vdx;
            n_q.vec_y = i_d.vec_y - w_vdy;
            n_q.vec_z = i_d.vec_z + ATAN;
        end else begin
            n_q.vec_x = i_d.vec_x - w_vdx;
            n_q.vec_y = i_d.vec_y + w_vdy;
            n_q.vec_z = i_d.vec_z - ATAN;
        end
        // rotation drives the residual angle toward zero
        if (i_d.rot_a >= 36'sd0) begin
            n_q.rot_x = i_d.rot_x - w_rdx;
            n_q.rot_y = i_d.rot_y + w_rdy;
            n_q.rot_a = i_d.rot_a - ATAN;
        end else begin
            n_q.rot_x = i_d.rot_x + w_rdx;
            n_q.rot_y = i_d.rot_y - w_rdy;
            n_q.rot_a = i_d.rot_a + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

/* hw/rtl/gpvc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gpvc_checker
// port level checks on the go-to-point command block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpvc_checker
    import gpvc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_out_beat   o_out_beat
);

    logic w_stall;
    logic w_sp_ok;
    assign w_stall = o_out_valid && !i_out_ready;
    assign w_sp_ok = (o_out_beat.heading_setpoint <= 16'(PI_Q13))
                  && (o_out_beat.heading_setpoint >= 16'(-PI_Q13));

    // a waiting result beat stays offered and unchanged
    `GPVC_ASSERT(a_out_hold, i_clk, i_rst_n, w_stall |=> o_out_valid)
    `GPVC_HOLD(a_out_stable, i_clk, i_rst_n, w_stall, o_out_beat)

    // input is refused only while the output stalls
    `GPVC_ASSERT(a_ready, i_clk, i_rst_n, o_in_ready == !w_stall)

    // setpoint stays within plus or minus pi
    `GPVC_ASSERT(a_sp_range, i_clk, i_rst_n, o_out_valid |-> w_sp_ok)

endmodule

bind goto_point_velocity_command gpvc_checker u_gpvc_checker (.*);
`default_nettype wire
